### rtl/core/dbas_pkg.sv
// ----------------------------------------------------------------------------
// dbas_pkg
// Types and the BCD digit cell shared by the add/subtract pipeline stages.
// ----------------------------------------------------------------------------
package dbas_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DigitW = 4;

  localparam logic [DigitW-1:0] DigitTen = 4'hA;
  localparam logic [DigitW-1:0] DigitSix = 4'h6;

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdSub = 1'b1;

  // request after operand masking
  typedef struct packed {
    logic             sub;
    logic             wide;
    logic             dec;
    logic             cin;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } dbas_req_t;

  // low half done: binary result plus the two low decimal digits
  typedef struct packed {
    logic             sub;
    logic             wide;
    logic             dec;
    logic [DataW:0]   bin;
    logic             ovf;
    logic [ByteW-1:0] dec_lo;
    logic             dec_cy;
    logic [ByteW-1:0] a_hi;
    logic [ByteW-1:0] b_hi;
  } dbas_mid_t;

  // one decimal digit; cy means carry for add and no-borrow for subtract
  // returns {cy_out, digit}
  function automatic logic [DigitW:0] digit_step(
    input logic              sub,
    input logic              cy,
    input logic [DigitW-1:0] a,
    input logic [DigitW-1:0] b
  );
    logic [DigitW:0]   t;
    logic [DigitW+1:0] x;
    logic [DigitW:0]   r;
    t = {1'b0, a} + {1'b0, b} + {{DigitW{1'b0}}, cy};
    x = {2'b00, a} - {2'b00, b} - {{(DigitW+1){1'b0}}, ~cy};
    if (sub == CmdSub) begin
      if (x[DigitW+1] || (x[DigitW:0] >= {1'b0, DigitTen})) begin
        r = {1'b0, x[DigitW-1:0] + DigitTen};
      end else begin
        r = {1'b1, x[DigitW-1:0]};
      end
    end else begin
      if (t >= {1'b0, DigitTen}) begin
        r = {1'b1, t[DigitW-1:0] + DigitSix};
      end else begin
        r = {1'b0, t[DigitW-1:0]};
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/decimal_binary_add_subtract_top.sv
// ----------------------------------------------------------------------------
// decimal_binary_add_subtract_top
// Pipelined binary/BCD add-with-carry and subtract-with-borrow unit.
// ----------------------------------------------------------------------------
// channel | signals                              | direction
// in      | in_valid_i, in_ready_o, request      | upstream to unit
// out     | out_valid_o, out_ready_i, result     | unit to downstream
//
// three register stages: operand capture, low digits plus binary sum,
// high digits plus result register; one request per cycle while out_ready_i does not stall
// reset clears only the stage valid bits
// a stage holds while its successor is full and stalled; ready ripples back
// ----------------------------------------------------------------------------
module decimal_binary_add_subtract_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic        wide_i,
  input  logic        decimal_mode_i,
  input  logic        carry_in_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] sum_o,
  output logic        carry_out_o,
  output logic        overflow_o
);

  logic                valid_q;
  dbas_pkg::dbas_req_t req_d, req_q;
  logic                lo_ready;
  logic                mid_valid;
  dbas_pkg::dbas_mid_t mid;
  logic                hi_ready;
  logic [15:0]         mask;

  assign in_ready_o = !valid_q || lo_ready;

  always_comb begin
    mask       = wide_i ? 16'hFFFF : 16'h00FF;
    req_d.sub  = command_i;
    req_d.wide = wide_i;
    req_d.dec  = decimal_mode_i;
    req_d.cin  = carry_in_i;
    req_d.a    = operand_a_i & mask;
    req_d.b    = operand_b_i & mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= req_d;
    end
  end

  dbas_lo_stage u_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q),
    .ready_o (lo_ready),
    .req_i   (req_q),
    .valid_o (mid_valid),
    .ready_i (hi_ready),
    .mid_o   (mid)
  );

  dbas_hi_stage u_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (hi_ready),
    .mid_i   (mid),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .sum_o   (sum_o),
    .carry_o (carry_out_o),
    .ovf_o   (overflow_o)
  );

endmodule

### rtl/core/dbas_lo_stage.sv
// ----------------------------------------------------------------------------
// dbas_lo_stage
// Binary sum with overflow, and the two low decimal digits.
// ----------------------------------------------------------------------------
module dbas_lo_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  dbas_pkg::dbas_req_t req_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dbas_pkg::dbas_mid_t mid_o
);

  logic                            valid_q;
  dbas_pkg::dbas_mid_t             mid_d, mid_q;
  logic [dbas_pkg::DataW-1:0]      mask;
  logic [dbas_pkg::DataW-1:0]      bb;
  logic [dbas_pkg::DataW-1:0]      sign;
  logic [dbas_pkg::DigitW:0]       dig0, dig1;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign mid_o   = mid_q;

  always_comb begin
    mask = req_i.wide ? 16'hFFFF : 16'h00FF;
    sign = req_i.wide ? 16'h8000 : 16'h0080;
    bb   = (req_i.sub == dbas_pkg::CmdSub) ? (req_i.b ^ mask) : req_i.b;
    dig0 = dbas_pkg::digit_step(req_i.sub, req_i.cin, req_i.a[3:0], req_i.b[3:0]);
    dig1 = dbas_pkg::digit_step(req_i.sub, dig0[4], req_i.a[7:4], req_i.b[7:4]);

    mid_d.sub    = req_i.sub;
    mid_d.wide   = req_i.wide;
    mid_d.dec    = req_i.dec;
    mid_d.bin    = {1'b0, req_i.a} + {1'b0, bb} + {16'h0000, req_i.cin};
    mid_d.ovf    = |(~(req_i.a ^ bb) & (req_i.a ^ mid_d.bin[15:0]) & sign);
    mid_d.dec_lo = {dig1[3:0], dig0[3:0]};
    mid_d.dec_cy = dig1[4];
    mid_d.a_hi   = req_i.a[15:8];
    mid_d.b_hi   = req_i.b[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mid_q <= mid_d;
    end
  end

endmodule

### rtl/core/dbas_hi_stage.sv
// ----------------------------------------------------------------------------
// dbas_hi_stage
// Two high decimal digits, width select and the result register.
// ----------------------------------------------------------------------------
module dbas_hi_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  dbas_pkg::dbas_mid_t        mid_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [dbas_pkg::DataW-1:0] sum_o,
  output logic                       carry_o,
  output logic                       ovf_o
);

  logic                       valid_q;
  logic [dbas_pkg::DataW-1:0] sum_d, sum_q;
  logic                       carry_d, carry_q;
  logic                       ovf_q;
  logic [dbas_pkg::DigitW:0]  dig2, dig3;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign carry_o = carry_q;
  assign ovf_o   = ovf_q;

  always_comb begin
    dig2 = dbas_pkg::digit_step(mid_i.sub, mid_i.dec_cy, mid_i.a_hi[3:0], mid_i.b_hi[3:0]);
    dig3 = dbas_pkg::digit_step(mid_i.sub, dig2[4], mid_i.a_hi[7:4], mid_i.b_hi[7:4]);
    if (mid_i.dec) begin
      if (mid_i.wide) begin
        sum_d   = {dig3[3:0], dig2[3:0], mid_i.dec_lo};
        carry_d = dig3[4];
      end else begin
        sum_d   = {8'h00, mid_i.dec_lo};
        carry_d = mid_i.dec_cy;
      end
    end else begin
      if (mid_i.wide) begin
        sum_d   = mid_i.bin[15:0];
        carry_d = mid_i.bin[16];
      end else begin
        sum_d   = {8'h00, mid_i.bin[7:0]};
        carry_d = mid_i.bin[8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sum_q   <= sum_d;
      carry_q <= carry_d;
      ovf_q   <= mid_i.ovf;
    end
  end

endmodule
